### src/fomp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fomp_pkg
// Shared types and constants of the first-order motor plant.
// ----------------------------------------------------------------------------
package fomp_pkg;

  localparam int unsigned MAX_RPM   = 3000;
  localparam int unsigned ADC_MAX   = 4095;

  localparam int unsigned DUTY_W    = 14;
  localparam int unsigned GAIN_W    = 16;
  localparam int unsigned FRAC_W    = 17;
  localparam int unsigned CODE_W    = 12;
  localparam int unsigned OP_W      = 32;
  localparam int unsigned PROD_W    = 61;
  localparam int unsigned ADDR_W    = 3;
  localparam int unsigned DATA_W    = 32;

  localparam logic [FRAC_W-1:0] FULL_SPEED = 17'd65536;
  localparam logic [DUTY_W-1:0] DUTY_FULL  = 14'd10000;
  localparam logic [29:0]       DUTY_HALF  = 30'd5000;

  // floor(x / 10000) == (x * RECIP_M) >> RECIP_SHIFT for every x below 2^30
  localparam logic [OP_W-1:0]   RECIP_M     = 32'd879609303;
  localparam int unsigned       RECIP_SHIFT = 43;

  // Register select: paddr bit 2 picks the word
  localparam logic REG_GAIN = 1'b0;
  localparam logic REG_LOAD = 1'b1;

  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic [FRAC_W-1:0] load;
  } fomp_cfg_t;

endpackage

### src/first_order_motor_plant.sv
`timescale 1ns / 1ps
// An input beat is taken only in the idle state, once the last beat has
// left the fin state; the single shared multiplier takes
// five products in turn (load scale, divide by 10000, lag step, rpm, adc).
// A finished result waits in the output register while the next beat is
// taken. Reset (rst_n low, synchronous) brings the motor to rest, clears
// both configuration registers and drops any pending result.
// ----------------------------------------------------------------------------
// first_order_motor_plant
// First-order lag DC motor model: each input beat is one sample tick with a
// PWM duty; each result beat reports the updated speed as a Q1.16 fraction,
// as rounded rpm and as a rounded ADC code.
// ----------------------------------------------------------------------------
module first_order_motor_plant
  import fomp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [15:0]       in_tdata,    // [13:0] duty, [15:14] zero
  // result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [47:0]       out_tdata,   // [16:0] speed_fraction,
                                         // [28:17] rpm code,
                                         // [40:29] speed_adc, [47:41] zero
  // configuration port
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready
);

  fomp_cfg_t                cfg_r;
  logic                     cfg_wr;

  logic signed [OP_W-1:0]   mul_a;
  logic signed [OP_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] mul_p;

  logic [FRAC_W-1:0]        speed_fraction;
  logic [CODE_W-1:0]        rpm_code;
  logic [CODE_W-1:0]        speed_adc;

  // Register file: gain at byte 0, load at byte 4; writes land in the
  // access phase. No wait states.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain <= '0;
      cfg_r.load <= '0;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_GAIN: cfg_r.gain <= cfg_pwdata[GAIN_W-1:0];
        REG_LOAD: cfg_r.load <= cfg_pwdata[FRAC_W-1:0];
        default:  cfg_r      <= cfg_r;
      endcase
    end
  end

  // Read back the selected register, zero-extended
  always_comb begin
    case (cfg_paddr[2])
      REG_GAIN: cfg_prdata = {{(DATA_W-GAIN_W){1'b0}}, cfg_r.gain};
      REG_LOAD: cfg_prdata = {{(DATA_W-FRAC_W){1'b0}}, cfg_r.load};
      default:  cfg_prdata = '0;
    endcase
  end

  // Shared multiplier: one product per cycle, registered
  fomp_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .mul_p (mul_p)
  );

  // Sequencer: steps one tick through the multiplier and holds the speed
  fomp_core u_core (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .in_valid           (in_tvalid),
    .in_ready           (in_tready),
    .in_duty            (in_tdata[DUTY_W-1:0]),
    .out_valid          (out_tvalid),
    .out_ready          (out_tready),
    .out_speed_fraction (speed_fraction),
    .out_rpm_code       (rpm_code),
    .out_speed_adc      (speed_adc),
    .mul_a              (mul_a),
    .mul_b              (mul_b),
    .mul_p              (mul_p)
  );

  // Pack the result beat, lowest field first, padded to whole bytes
  assign out_tdata = {7'b0, speed_adc, rpm_code, speed_fraction};

endmodule

### src/fomp_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fomp_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module fomp_mul
  import fomp_pkg::*;
(
  input  logic                     clk,
  input  logic signed [OP_W-1:0]   mul_a,
  input  logic signed [OP_W-1:0]   mul_b,
  output logic signed [PROD_W-1:0] mul_p
);

  logic signed [2*OP_W-1:0] prod;
  logic signed [PROD_W-1:0] p_r;

  assign prod  = mul_a * mul_b;
  assign mul_p = p_r;

  always_ff @(posedge clk) begin
    p_r <= prod[PROD_W-1:0];
  end

endmodule

### src/fomp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fomp_core
// Sequencer and datapath: target, lag update and output scaling, all on
// the shared multiplier.
// ----------------------------------------------------------------------------
module fomp_core
  import fomp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  fomp_cfg_t                cfg,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [DUTY_W-1:0]        in_duty,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [FRAC_W-1:0]        out_speed_fraction,
  output logic [CODE_W-1:0]        out_rpm_code,
  output logic [CODE_W-1:0]        out_speed_adc,
  output logic signed [OP_W-1:0]   mul_a,
  output logic signed [OP_W-1:0]   mul_b,
  input  logic signed [PROD_W-1:0] mul_p
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RECIP,
    ST_STEP,
    ST_UPD,
    ST_RPM,
    ST_ADC,
    ST_FIN
  } state_t;

  state_t              state_r;
  logic [DUTY_W-1:0]   duty_r;
  logic [FRAC_W-1:0]   speed_r;
  logic [CODE_W-1:0]   rpm_r;
  logic                out_valid_r;
  logic [FRAC_W-1:0]   frac_out_r;
  logic [CODE_W-1:0]   rpm_out_r;
  logic [CODE_W-1:0]   adc_out_r;

  logic [DUTY_W-1:0]   duty_c;
  logic [FRAC_W-1:0]   load_c;
  logic [FRAC_W-1:0]   one_minus_load;
  logic [29:0]         recip_in;
  logic [FRAC_W-1:0]   target;
  logic signed [17:0]  diff;
  logic signed [PROD_W-1:0] step_adj;
  logic signed [18:0]  step_q;
  logic signed [19:0]  speed_sum;
  logic [FRAC_W-1:0]   speed_nxt;
  logic [32:0]         scaled;
  logic                in_fire;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  assign duty_c         = (in_duty > DUTY_FULL) ? DUTY_FULL : in_duty;
  assign load_c         = (cfg.load > FULL_SPEED) ? FULL_SPEED : cfg.load;
  assign one_minus_load = FULL_SPEED - load_c;
  assign recip_in       = mul_p[29:0] + DUTY_HALF;
  assign target         = mul_p[RECIP_SHIFT+FRAC_W-1:RECIP_SHIFT];
  assign diff           = $signed({1'b0, target}) - $signed({1'b0, speed_r});

  // Round half towards +inf on the Q0.32 step, then clamp to 0..full speed
  assign step_adj  = mul_p + $signed({{(PROD_W-17){1'b0}}, 17'd32768});
  assign step_q    = step_adj[34:16];
  assign speed_sum = $signed({3'b000, speed_r}) + $signed({step_q[18], step_q});

  always_comb begin
    if (cfg.gain == '0) begin
      speed_nxt = speed_r;
    end else if (speed_sum < 0) begin
      speed_nxt = '0;
    end else if (speed_sum > $signed({3'b000, FULL_SPEED})) begin
      speed_nxt = FULL_SPEED;
    end else begin
      speed_nxt = speed_sum[FRAC_W-1:0];
    end
  end

  assign scaled = {1'b0, mul_p[31:0]} + 33'd32768;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_LOAD: begin
        mul_a = $signed({{(OP_W-DUTY_W){1'b0}}, duty_r});
        mul_b = $signed({{(OP_W-FRAC_W){1'b0}}, one_minus_load});
      end
      ST_RECIP: begin
        mul_a = $signed({2'b00, recip_in});
        mul_b = $signed(RECIP_M);
      end
      ST_STEP: begin
        mul_a = $signed({{(OP_W-GAIN_W){1'b0}}, cfg.gain});
        mul_b = $signed({{(OP_W-18){diff[17]}}, diff});
      end
      ST_RPM: begin
        mul_a = $signed({{(OP_W-FRAC_W){1'b0}}, speed_r});
        mul_b = $signed(OP_W'(MAX_RPM));
      end
      // keep the adc product standing while the result waits
      ST_ADC, ST_FIN: begin
        mul_a = $signed({{(OP_W-FRAC_W){1'b0}}, speed_r});
        mul_b = $signed(OP_W'(ADC_MAX));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      speed_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != ST_FIN) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            duty_r  <= duty_c;
            state_r <= ST_LOAD;
          end
        end
        ST_LOAD:  state_r <= ST_RECIP;
        ST_RECIP: state_r <= ST_STEP;
        ST_STEP:  state_r <= ST_UPD;
        ST_UPD: begin
          speed_r <= speed_nxt;
          state_r <= ST_RPM;
        end
        ST_RPM:   state_r <= ST_ADC;
        ST_ADC: begin
          rpm_r   <= scaled[16+CODE_W-1:16];
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          // hold until the output register is free
          if (!out_valid_r || out_ready) begin
            frac_out_r  <= speed_r;
            rpm_out_r   <= rpm_r;
            adc_out_r   <= scaled[16+CODE_W-1:16];
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_speed_fraction = frac_out_r;
  assign out_rpm_code       = rpm_out_r;
  assign out_speed_adc      = adc_out_r;

`ifndef SYNTHESIS
  a_speed_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    speed_r <= FULL_SPEED)
    else $error("speed state above full speed");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_LOAD))
    else $error("accepted beat did not start the sequence");

  a_zero_gain_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD && cfg.gain == '0) |=> (speed_r == $past(speed_r)))
    else $error("speed moved with zero gain");

  a_fin_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && (!out_valid_r || out_ready)) |=>
      (out_valid_r && frac_out_r == speed_r))
    else $error("finished result not loaded into output register");
`endif

endmodule

### verif/first_order_motor_plant_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_order_motor_plant_test
// Self-checking bench for the motor plant. Duty beats go in on the input
// stream. A scoreboard keeps its own copy of the lag state and the two
// registers, and it works out the speed beat that each duty beat should
// give. Results are compared field by field in arrival order. A directed
// opening pass covers the corner cases. Randomised duty runs follow under
// changing register settings and four flow-control patterns.
// ----------------------------------------------------------------------------
module first_order_motor_plant_test;
  import fomp_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned CHUNKS       = 10;
  localparam int unsigned CHUNK_BEATS  = 175;
  localparam int unsigned TAIL_CYCLES  = 16;
  localparam int unsigned PRINT_LIMIT  = 40;

  // --------------------------------------------------------------------------
  // Scoreboard: lag predictor plus the queue of speed beats still due
  // --------------------------------------------------------------------------
  class speed_scoreboard;
    typedef struct packed {
      logic [FRAC_W-1:0] frac;
      logic [CODE_W-1:0] rpm;
      logic [CODE_W-1:0] adc;
    } speed_beat_t;

    logic [GAIN_W-1:0] gain;
    logic [FRAC_W-1:0] load;
    logic [FRAC_W-1:0] speed;
    speed_beat_t       due_q[$];
    int unsigned       errors;
    int unsigned       results_seen;

    function new();
      gain         = '0;
      load         = '0;
      speed        = '0;
      errors       = 0;
      results_seen = 0;
    endfunction

    function void report(string what, longint got, longint want);
      if (errors < PRINT_LIMIT)
        $display("%0t mismatch: %s got %0d want %0d", $time, what, got, want);
      errors++;
    endfunction

    function int unsigned pending();
      return due_q.size();
    endfunction

    function void set_register(logic sel, logic [DATA_W-1:0] value);
      if (sel == REG_GAIN)
        gain = value[GAIN_W-1:0];
      else
        load = value[FRAC_W-1:0];
    endfunction

    function void check_register(logic sel, logic [DATA_W-1:0] got);
      logic [DATA_W-1:0] want;
      want = (sel == REG_GAIN) ? DATA_W'(gain) : DATA_W'(load);
      if (got !== want)
        report(sel == REG_GAIN ? "gain readback" : "load readback", got, want);
    endfunction

    // Advance the lag by one tick and queue the speed beat it produces.
    function void note_duty(logic [DUTY_W-1:0] duty);
      longint unsigned d;
      longint unsigned l;
      longint unsigned target;
      longint unsigned scaled;
      longint          diff;
      longint          nxt;
      speed_beat_t     beat;
      d = duty;
      l = load;
      if (d > DUTY_FULL) d = DUTY_FULL;
      if (l > FULL_SPEED) l = FULL_SPEED;
      // a zero gain freezes the speed but still reports it
      if (gain != 0) begin
        target = (d * (FULL_SPEED - l) + DUTY_HALF) / DUTY_FULL;
        diff   = longint'(target) - longint'(speed);
        // round half towards plus infinity is a floor of the biased product
        nxt    = longint'(speed) + ((longint'(gain) * diff + 32768) >>> 16);
        if (nxt < 0) nxt = 0;
        if (nxt > longint'(FULL_SPEED)) nxt = FULL_SPEED;
        speed  = nxt[FRAC_W-1:0];
      end
      beat.frac = speed;
      scaled    = (longint'(speed) * MAX_RPM + 32768) >> 16;
      beat.rpm  = scaled[CODE_W-1:0];
      scaled    = (longint'(speed) * ADC_MAX + 32768) >> 16;
      beat.adc  = scaled[CODE_W-1:0];
      due_q.push_back(beat);
    endfunction

    function void check_result(logic [47:0] tdata);
      speed_beat_t want;
      results_seen++;
      if (due_q.size() == 0) begin
        report("unexpected speed beat", tdata[16:0], 0);
        return;
      end
      want = due_q.pop_front();
      if (tdata[16:0] !== want.frac)  report("speed_fraction", tdata[16:0], want.frac);
      if (tdata[28:17] !== want.rpm)  report("rpm code", tdata[28:17], want.rpm);
      if (tdata[40:29] !== want.adc)  report("speed_adc", tdata[40:29], want.adc);
      if (tdata[47:41] !== 7'd0)      report("tdata padding", tdata[47:41], 0);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block hookup; every input holds a known value from time zero
  // --------------------------------------------------------------------------
  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_tvalid   = 1'b0;
  logic              in_tready;
  logic [15:0]       in_tdata    = '0;   // [13:0] duty, [15:14] zero
  logic              out_tvalid;
  logic              out_tready  = 1'b0;
  logic [47:0]       out_tdata;          // [16:0] fraction, [28:17] rpm,
                                         // [40:29] adc, [47:41] zero
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr   = '0;
  logic [DATA_W-1:0] cfg_pwdata  = '0;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  first_order_motor_plant i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  speed_scoreboard sb = new();

  int unsigned send_idle_pct = 0;   // chance per cycle that the sender holds off
  int unsigned stall_pct     = 0;   // chance per cycle that the receiver stalls
  int unsigned cycle_count   = 0;
  int unsigned duty_beats    = 0;
  int unsigned settings_seen = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver back-pressure: a fresh draw every cycle.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Check every speed beat on the edge that accepts it.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata);
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Watchdog expired after %0d cycles", cycle_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Offer one duty beat. Leave tvalid high on return so that a following beat
  // can go out back to back; the next call or the caller drops it.
  task automatic push_duty(input logic [DUTY_W-1:0] duty);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, duty};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_duty(duty);
    duty_beats++;
  endtask

  // One register access: setup cycle, then access until pready.
  // Leave psel high on return so accesses can run back to back.
  task automatic cfg_access(input logic sel, input logic write,
                            input logic [DATA_W-1:0] wdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= write;
    cfg_paddr   <= {sel, 2'b00};
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (write)
      sb.set_register(sel, wdata);
    else
      sb.check_register(sel, cfg_prdata);
  endtask

  // Write both registers and read each one back. Junk goes in the unused
  // upper bits of pwdata to show that they are dropped.
  task automatic program_plant(input logic [GAIN_W-1:0] gain,
                               input logic [FRAC_W-1:0] load);
    cfg_access(REG_GAIN, 1'b1, {16'($urandom), gain});
    cfg_access(REG_GAIN, 1'b0, '0);
    cfg_access(REG_LOAD, 1'b1, {15'($urandom), load});
    cfg_access(REG_LOAD, 1'b0, '0);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    settings_seen++;
  endtask

  // Drop tvalid and hold until every speed beat in flight has come back.
  task automatic drain_plant();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [DUTY_W-1:0] pick_duty();
    case ($urandom_range(9))
      0:       return '0;
      1:       return DUTY_FULL;
      2:       return DUTY_W'($urandom_range(16383, 10001));
      3:       return DUTY_W'($urandom_range(16383));
      default: return DUTY_W'($urandom_range(10000));
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(7))
      0:       return '0;
      1:       return 16'd1;
      2:       return 16'hFFFF;
      3:       return GAIN_W'($urandom_range(255, 1));
      default: return GAIN_W'($urandom_range(65535, 2048));
    endcase
  endfunction

  function automatic logic [FRAC_W-1:0] pick_load();
    case ($urandom_range(5))
      0:       return '0;
      1:       return FULL_SPEED;
      2:       return FRAC_W'($urandom_range(131071, 65537));
      default: return FRAC_W'($urandom_range(65535));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned sent;
    int unsigned hold;
    logic [DUTY_W-1:0] duty;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Both registers must read back as zero straight out of reset.
    cfg_access(REG_GAIN, 1'b0, '0);
    cfg_access(REG_LOAD, 1'b0, '0);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);

    // Zero gain out of reset: the motor stays at rest whatever the duty.
    push_duty(DUTY_FULL);
    push_duty(14'h3FFF);

    // Fastest lag, no load: climb to full speed, then exercise duty clamping.
    drain_plant();
    program_plant(16'hFFFF, '0);
    push_duty(14'h3FFF);
    push_duty(14'h3FFF);
    push_duty(DUTY_FULL);
    push_duty(14'd10001);
    push_duty(14'd0);
    push_duty(14'd5000);
    push_duty(14'd1);
    push_duty(14'd9999);

    // Full load, then load above full: target is zero either way.
    drain_plant();
    program_plant(16'hFFFF, FULL_SPEED);
    push_duty(DUTY_FULL);
    push_duty(DUTY_FULL);
    drain_plant();
    program_plant(16'h8000, 17'h1FFFF);
    push_duty(DUTY_FULL);
    push_duty(14'h2AAA);

    // Slowest non-zero lag, then freeze mid-way with the gain at zero.
    drain_plant();
    program_plant(16'd1, 17'd32768);
    push_duty(DUTY_FULL);
    push_duty(14'h1555);
    drain_plant();
    program_plant(16'hC000, 17'd1);
    push_duty(14'd7777);
    push_duty(14'd7777);
    drain_plant();
    program_plant('0, 17'd20000);
    push_duty(DUTY_FULL);
    push_duty(14'd0);

    // Random part: held duty runs so the lag settles, with the odd single
    // beat as noise; cycle through the four flow-control patterns.
    for (int unsigned chunk = 0; chunk < CHUNKS; chunk++) begin
      drain_plant();
      case (chunk % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 75; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 75; end
        default: begin send_idle_pct = 27; stall_pct = 27; end
      endcase
      program_plant(pick_gain(), pick_load());
      sent = 0;
      while (sent < CHUNK_BEATS) begin
        duty = pick_duty();
        hold = ($urandom_range(4) == 0) ? 1 : $urandom_range(24, 2);
        for (int unsigned k = 0; k < hold && sent < CHUNK_BEATS; k++) begin
          push_duty(duty);
          sent++;
        end
      end
    end

    // Settle: wait for the last beats, then give the pipeline time to show
    // any stray result.
    drain_plant();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d duty beats and %0d speed beats under %0d register settings,",
             duty_beats, sb.results_seen, settings_seen);
    $display("with free flow, sender gaps, receiver stalls and both together.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d speed beats never arrived", sb.errors, sb.pending());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
